>>> rtl/core/rvc_pkg.sv
// Shared constants, codes and types of the RV32I subset core.
package rvc_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned REG_COUNT  = 32;
  localparam int unsigned REG_AW     = $clog2(REG_COUNT);
  // Data store depth; a power of two so the word index is a plain bit-select
  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned DATA_AW    = $clog2(DATA_WORDS);

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 136;

  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
  localparam logic [6:0] OPC_ITYPE  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JUMP   = 7'b1101111;

  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_AND = 3'b111;
  localparam logic [2:0] F3_OR  = 3'b110;

  typedef enum logic [2:0] {
    SEL_AND,
    SEL_OR,
    SEL_ADD,
    SEL_SUB,
    SEL_MUL,
    SEL_NONE
  } alu_sel_e;

  // Outcome of one instruction, carried from execute to the output stage
  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              branch_taken;
    logic              reg_written;
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   write_value;
    logic              is_load;
    logic              mem_written;
    logic [XLEN-1:0]   mem_address;
    logic [XLEN-1:0]   store_value;
  } exec_res_t;

endpackage

>>> rtl/core/single_cycle_rv32_subset_core.sv
// RV32I subset core: one instruction word in, one result word out per instruction.
// Each instruction word is registered in stage 1, then its result word in the output stage.
// Throughput: one instruction per cycle without back-pressure; each uses the register file read
// ports once and the data store at most once, with operand forwarding from the output stage.
// Reset: pc and register file read as zero; the data store is cleared one word per cycle,
// over all DATA_WORDS (1024) words, and no instruction word is taken until the clear is done.
module single_cycle_rv32_subset_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] instr_word
  input  logic [rvc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] next_pc, [32] branch_taken, [33] reg_written, [38:34] dest_index,
  // [70:39] write_value, [71] mem_written, [103:72] mem_address, [135:104] store_value
  output logic [rvc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  logic                          clr_busy_q;
  logic [rvc_pkg::DATA_AW-1:0]   clr_idx_q;

  logic                          s1_valid_q, s2_valid_q;
  logic [rvc_pkg::XLEN-1:0]      s1_instr_q;
  logic [rvc_pkg::XLEN-1:0]      pc_q;
  rvc_pkg::exec_res_t            ex_res, s2_q;

  logic                          in_acc, s1_adv, out_pop;
  logic [rvc_pkg::XLEN-1:0]      rf_a, rf_b, op_a, op_b, out_wval;
  logic                          fwd_a, fwd_b;

  logic [rvc_pkg::XLEN-1:0]      dmem [rvc_pkg::DATA_WORDS];
  logic [rvc_pkg::XLEN-1:0]      dmem_rdata_q;
  logic [rvc_pkg::DATA_AW-1:0]   dm_idx;

  assign out_pop       = s2_valid_q && m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s2_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Clear the data store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + rvc_pkg::DATA_AW'(1);
      if (clr_idx_q == rvc_pkg::DATA_AW'(rvc_pkg::DATA_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      pc_q       <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
        pc_q       <= ex_res.next_pc;
      end else if (out_pop) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_instr_q <= s_axis_tdata[31:0];
    end
    if (s1_adv) begin
      s2_q <= ex_res;
    end
  end

  // Commit the register write as the word leaves the output stage
  rvc_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .raddr_a_i (s_axis_tdata[19:15]),
    .raddr_b_i (s_axis_tdata[24:20]),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b),
    .we_i      (out_pop && s2_q.reg_written),
    .waddr_i   (s2_q.dest_index),
    .wdata_i   (out_wval)
  );

  assign out_wval = s2_q.is_load ? dmem_rdata_q : s2_q.write_value;

  // Forward the uncommitted result held in the output stage
  assign fwd_a = s2_valid_q && s2_q.reg_written && (s2_q.dest_index == s1_instr_q[19:15]);
  assign fwd_b = s2_valid_q && s2_q.reg_written && (s2_q.dest_index == s1_instr_q[24:20]);
  assign op_a  = fwd_a ? out_wval : rf_a;
  assign op_b  = fwd_b ? out_wval : rf_b;

  rvc_exec u_exec (
    .instr_i (s1_instr_q),
    .pc_i    (pc_q),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .res_o   (ex_res)
  );

  // Word index wraps at the store depth
  assign dm_idx = ex_res.mem_address[rvc_pkg::DATA_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      dmem[clr_idx_q] <= '0;
    end else if (s1_adv && ex_res.mem_written) begin
      dmem[dm_idx] <= ex_res.store_value;
    end
    if (s1_adv && ex_res.is_load) begin
      dmem_rdata_q <= dmem[dm_idx];
    end
  end

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {s2_q.store_value, s2_q.mem_address, s2_q.mem_written, out_wval,
                          s2_q.dest_index, s2_q.reg_written, s2_q.branch_taken,
                          s2_q.next_pc};

endmodule

>>> rtl/core/rvc_regfile.sv
// Register file: two registered read ports with write-first bypass, one write port.
module rvc_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [rvc_pkg::REG_AW-1:0]    raddr_a_i,
  input  logic [rvc_pkg::REG_AW-1:0]    raddr_b_i,
  output logic [rvc_pkg::XLEN-1:0]      rdata_a_o,
  output logic [rvc_pkg::XLEN-1:0]      rdata_b_o,
  input  logic                          we_i,
  input  logic [rvc_pkg::REG_AW-1:0]    waddr_i,
  input  logic [rvc_pkg::XLEN-1:0]      wdata_i
);

  logic [rvc_pkg::XLEN-1:0]      rf_mem [rvc_pkg::REG_COUNT];
  logic [rvc_pkg::REG_COUNT-1:0] valid_q;

  logic [rvc_pkg::XLEN-1:0] mem_a_q, mem_b_q, byp_q;
  logic                     hit_a_q, hit_b_q, ok_a_q, ok_b_q;

  // Unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rf_mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      mem_a_q <= rf_mem[raddr_a_i];
      mem_b_q <= rf_mem[raddr_b_i];
      ok_a_q  <= valid_q[raddr_a_i];
      ok_b_q  <= valid_q[raddr_b_i];
      hit_a_q <= we_i && (waddr_i == raddr_a_i);
      hit_b_q <= we_i && (waddr_i == raddr_b_i);
      byp_q   <= wdata_i;
    end
  end

  assign rdata_a_o = hit_a_q ? byp_q : (ok_a_q ? mem_a_q : '0);
  assign rdata_b_o = hit_b_q ? byp_q : (ok_b_q ? mem_b_q : '0);

endmodule

>>> rtl/core/rvc_exec.sv
// Decode, immediates, ALU and next-pc logic for one instruction.
module rvc_exec (
  input  logic [rvc_pkg::XLEN-1:0] instr_i,
  input  logic [rvc_pkg::XLEN-1:0] pc_i,
  input  logic [rvc_pkg::XLEN-1:0] op_a_i,
  input  logic [rvc_pkg::XLEN-1:0] op_b_i,
  output rvc_pkg::exec_res_t       res_o
);

  logic [6:0]                 opc, f7;
  logic [2:0]                 f3;
  logic [rvc_pkg::REG_AW-1:0] rd;
  logic [rvc_pkg::XLEN-1:0]   imm_i, imm_s, imm_b2, imm_j2;
  logic [rvc_pkg::XLEN-1:0]   alu_b, alu_out;
  rvc_pkg::alu_sel_e          rsel, isel, sel;

  assign opc = instr_i[6:0];
  assign rd  = instr_i[11:7];
  assign f3  = instr_i[14:12];
  assign f7  = instr_i[31:25];

  assign imm_i  = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s  = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  // Branch and jump offsets already doubled
  assign imm_b2 = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                   instr_i[11:8], 1'b0};
  assign imm_j2 = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                   instr_i[30:21], 1'b0};

  always_comb begin
    rsel = rvc_pkg::SEL_NONE;
    if (f7 == rvc_pkg::F7_BASE && f3 == rvc_pkg::F3_ADD) begin
      rsel = rvc_pkg::SEL_ADD;
    end else if (f7 == rvc_pkg::F7_ALT && f3 == rvc_pkg::F3_ADD) begin
      rsel = rvc_pkg::SEL_SUB;
    end else if (f7 == rvc_pkg::F7_BASE && f3 == rvc_pkg::F3_AND) begin
      rsel = rvc_pkg::SEL_AND;
    end else if (f7 == rvc_pkg::F7_BASE && f3 == rvc_pkg::F3_OR) begin
      rsel = rvc_pkg::SEL_OR;
    end else if (f7 == rvc_pkg::F7_MULDIV && f3 == rvc_pkg::F3_ADD) begin
      rsel = rvc_pkg::SEL_MUL;
    end
  end

  always_comb begin
    case (f3)
      rvc_pkg::F3_ADD: isel = rvc_pkg::SEL_ADD;
      rvc_pkg::F3_AND: isel = rvc_pkg::SEL_AND;
      rvc_pkg::F3_OR:  isel = rvc_pkg::SEL_OR;
      default:         isel = rvc_pkg::SEL_NONE;
    endcase
  end

  always_comb begin
    case (opc)
      rvc_pkg::OPC_RTYPE: begin
        sel   = rsel;
        alu_b = op_b_i;
      end
      rvc_pkg::OPC_ITYPE: begin
        sel   = isel;
        alu_b = imm_i;
      end
      rvc_pkg::OPC_STORE: begin
        sel   = rvc_pkg::SEL_ADD;
        alu_b = imm_s;
      end
      default: begin
        sel   = rvc_pkg::SEL_ADD;
        alu_b = imm_i;
      end
    endcase
  end

  always_comb begin
    case (sel)
      rvc_pkg::SEL_ADD: alu_out = op_a_i + alu_b;
      rvc_pkg::SEL_SUB: alu_out = op_a_i - alu_b;
      rvc_pkg::SEL_AND: alu_out = op_a_i & alu_b;
      rvc_pkg::SEL_OR:  alu_out = op_a_i | alu_b;
      rvc_pkg::SEL_MUL: alu_out = op_a_i * alu_b;
      default:          alu_out = '0;
    endcase
  end

  always_comb begin
    res_o              = '0;
    res_o.next_pc      = pc_i + rvc_pkg::XLEN'(4);
    res_o.dest_index   = rd;
    case (opc)
      rvc_pkg::OPC_RTYPE, rvc_pkg::OPC_ITYPE: begin
        res_o.write_value = alu_out;
        res_o.reg_written = 1'b1;
      end
      rvc_pkg::OPC_LOAD: begin
        res_o.mem_address = alu_out;
        res_o.reg_written = 1'b1;
        res_o.is_load     = 1'b1;
      end
      rvc_pkg::OPC_STORE: begin
        res_o.mem_address = alu_out;
        res_o.store_value = op_b_i;
        res_o.mem_written = 1'b1;
      end
      rvc_pkg::OPC_BRANCH: begin
        if (op_a_i == op_b_i) begin
          res_o.next_pc      = pc_i + imm_b2;
          res_o.branch_taken = 1'b1;
        end
      end
      rvc_pkg::OPC_JUMP: begin
        res_o.next_pc      = pc_i + imm_j2;
        res_o.branch_taken = 1'b1;
      end
      default: ;
    endcase
    // x0 is never written
    if (rd == '0) begin
      res_o.reg_written = 1'b0;
      res_o.write_value = '0;
      res_o.is_load     = 1'b0;
    end
  end

endmodule

>>> tb/single_cycle_rv32_subset_core_tb.sv
// Self-checking testbench of the RV32I subset core: mirrored execution, random stalls.
`timescale 1ns / 100ps

module single_cycle_rv32_subset_core_tb;

  localparam int unsigned RANDOM_ITEMS   = 1126;
  localparam int unsigned QUIET_TAIL     = 150;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_PRINTED    = 40;

  // Packed so that it lines up with the result word, first field highest
  typedef struct packed {
    logic [rvc_pkg::XLEN-1:0] store_value;
    logic [rvc_pkg::XLEN-1:0] mem_address;
    logic                     mem_written;
    logic [rvc_pkg::XLEN-1:0] write_value;
    logic [4:0]               dest_index;
    logic                     reg_written;
    logic                     branch_taken;
    logic [rvc_pkg::XLEN-1:0] next_pc;
  } commit_t;

  // Mirror of the architectural state plus the commits still owed by the core
  class core_mirror;
    logic [rvc_pkg::XLEN-1:0] pc;
    logic [rvc_pkg::XLEN-1:0] regs [rvc_pkg::REG_COUNT];
    logic [rvc_pkg::XLEN-1:0] dmem [rvc_pkg::DATA_WORDS];
    commit_t                  pending_commits[$];
    logic [31:0]              pending_instrs[$];
    int unsigned              mismatches;

    function new();
      pc = '0;
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return pending_commits.size();
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function logic [rvc_pkg::XLEN-1:0] alu(rvc_pkg::alu_sel_e sel,
                                           logic [rvc_pkg::XLEN-1:0] a,
                                           logic [rvc_pkg::XLEN-1:0] b);
      case (sel)
        rvc_pkg::SEL_ADD: return a + b;
        rvc_pkg::SEL_SUB: return a - b;
        rvc_pkg::SEL_AND: return a & b;
        rvc_pkg::SEL_OR:  return a | b;
        rvc_pkg::SEL_MUL: return a * b;
        default:          return '0;
      endcase
    endfunction

    function void note_instr(logic [31:0] w);
      logic [6:0]               opc;
      logic [4:0]               rd;
      logic [2:0]               f3;
      logic [6:0]               f7;
      logic [rvc_pkg::XLEN-1:0] a, b, imm_i, imm_s, imm_b, imm_j, res;
      rvc_pkg::alu_sel_e        sel;
      commit_t                  c;
      opc   = w[6:0];
      rd    = w[11:7];
      f3    = w[14:12];
      f7    = w[31:25];
      a     = regs[w[19:15]];
      b     = regs[w[24:20]];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{20{w[31]}}, w[31], w[7], w[30:25], w[11:8]};
      imm_j = {{12{w[31]}}, w[31], w[19:12], w[20], w[30:21]};
      c = '0;
      c.next_pc    = pc + 32'd4;
      c.dest_index = rd;
      case (opc)
        rvc_pkg::OPC_RTYPE: begin
          if (f7 == rvc_pkg::F7_BASE && f3 == rvc_pkg::F3_ADD) sel = rvc_pkg::SEL_ADD;
          else if (f7 == rvc_pkg::F7_ALT && f3 == rvc_pkg::F3_ADD) sel = rvc_pkg::SEL_SUB;
          else if (f7 == rvc_pkg::F7_BASE && f3 == rvc_pkg::F3_AND) sel = rvc_pkg::SEL_AND;
          else if (f7 == rvc_pkg::F7_BASE && f3 == rvc_pkg::F3_OR) sel = rvc_pkg::SEL_OR;
          else if (f7 == rvc_pkg::F7_MULDIV && f3 == rvc_pkg::F3_ADD) sel = rvc_pkg::SEL_MUL;
          else sel = rvc_pkg::SEL_NONE;
          c.write_value = alu(sel, a, b);
          c.reg_written = 1'b1;
        end
        rvc_pkg::OPC_ITYPE: begin
          // funct7 bits belong to the immediate here
          case (f3)
            rvc_pkg::F3_ADD: sel = rvc_pkg::SEL_ADD;
            rvc_pkg::F3_AND: sel = rvc_pkg::SEL_AND;
            rvc_pkg::F3_OR:  sel = rvc_pkg::SEL_OR;
            default:         sel = rvc_pkg::SEL_NONE;
          endcase
          c.write_value = alu(sel, a, imm_i);
          c.reg_written = 1'b1;
        end
        rvc_pkg::OPC_LOAD: begin
          res = a + imm_i;
          c.mem_address = res;
          c.write_value = dmem[res % rvc_pkg::DATA_WORDS];
          c.reg_written = 1'b1;
        end
        rvc_pkg::OPC_STORE: begin
          res = a + imm_s;
          c.mem_address = res;
          c.store_value = b;
          c.mem_written = 1'b1;
          dmem[res % rvc_pkg::DATA_WORDS] = b;
        end
        rvc_pkg::OPC_BRANCH: begin
          if (a == b) begin
            c.next_pc      = pc + (imm_b << 1);
            c.branch_taken = 1'b1;
          end
        end
        rvc_pkg::OPC_JUMP: begin
          c.next_pc      = pc + (imm_j << 1);
          c.branch_taken = 1'b1;
        end
        default: ;
      endcase
      // x0 swallows every write
      if (c.reg_written && rd != 5'd0) begin
        regs[rd] = c.write_value;
      end else begin
        c.reg_written = 1'b0;
        c.write_value = '0;
      end
      pc = c.next_pc;
      pending_commits = {pending_commits, c};
      pending_instrs  = {pending_instrs, w};
    endfunction

    task check_commit(logic [rvc_pkg::OUT_TDATA_W-1:0] d);
      commit_t     got, want;
      logic [31:0] w;
      got = d;
      if (pending_commits.size() == 0) begin
        report($sformatf("result word %h with no instruction waiting", d));
      end else begin
        want = pending_commits.pop_front();
        w    = pending_instrs.pop_front();
        if (got.next_pc !== want.next_pc)
          report($sformatf("instr %h next_pc %h want %h", w, got.next_pc, want.next_pc));
        if (got.branch_taken !== want.branch_taken)
          report($sformatf("instr %h branch_taken %b want %b", w, got.branch_taken,
                           want.branch_taken));
        if (got.reg_written !== want.reg_written)
          report($sformatf("instr %h reg_written %b want %b", w, got.reg_written,
                           want.reg_written));
        if (got.dest_index !== want.dest_index)
          report($sformatf("instr %h dest_index %0d want %0d", w, got.dest_index,
                           want.dest_index));
        if (got.write_value !== want.write_value)
          report($sformatf("instr %h write_value %h want %h", w, got.write_value,
                           want.write_value));
        if (got.mem_written !== want.mem_written)
          report($sformatf("instr %h mem_written %b want %b", w, got.mem_written,
                           want.mem_written));
        if (got.mem_address !== want.mem_address)
          report($sformatf("instr %h mem_address %h want %h", w, got.mem_address,
                           want.mem_address));
        if (got.store_value !== want.store_value)
          report($sformatf("instr %h store_value %h want %h", w, got.store_value,
                           want.store_value));
      end
    endtask
  endclass

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rvc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rvc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  logic                            gaps_on       = 1'b1;
  int unsigned                     sink_hold     = 0;
  core_mirror                      mirror;
  logic [31:0]                     directed [$];

  single_cycle_rv32_subset_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Instruction encoders; branch and jump offsets are given in half-words
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvc_pkg::OPC_RTYPE};
  endfunction

  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [11:0] imm, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvc_pkg::OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [11:0] v, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {v[11], v[9:4], rs2, rs1, f3, v[3:0], v[10], rvc_pkg::OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [19:0] v, logic [4:0] rd);
    return {v[19], v[9:0], v[10], v[18:11], rd, rvc_pkg::OPC_JUMP};
  endfunction

  // Favour the low registers so that results feed later instructions
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'($urandom);
    return 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] imm;
    int unsigned pick;
    rd   = pick_reg();
    rs1  = pick_reg();
    rs2  = pick_reg();
    imm  = 12'($urandom);
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       f3 = rvc_pkg::F3_ADD;
      1:       f3 = rvc_pkg::F3_AND;
      2:       f3 = rvc_pkg::F3_OR;
      default: f3 = 3'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0, 1:    f7 = rvc_pkg::F7_BASE;
      2:       f7 = rvc_pkg::F7_ALT;
      3:       f7 = rvc_pkg::F7_MULDIV;
      default: f7 = 7'($urandom);
    endcase
    // Loads and stores often share a small window off x0 so loads hit stored words
    if (pick >= 38 && pick < 66 && $urandom_range(0, 1) == 1) begin
      rs1 = 5'd0;
      imm = 12'($urandom_range(0, 15));
    end
    if (pick >= 66 && pick < 78 && $urandom_range(0, 1) == 1) rs2 = rs1;
    if (pick < 20) return enc_r(f7, rs2, rs1, f3, rd);
    if (pick < 38) return enc_i(rvc_pkg::OPC_ITYPE, imm, rs1, f3, rd);
    if (pick < 52) return enc_i(rvc_pkg::OPC_LOAD, imm, rs1, 3'($urandom), rd);
    if (pick < 66) return enc_s(imm, rs2, rs1, 3'($urandom));
    if (pick < 78) return enc_b(imm, rs2, rs1, 3'($urandom));
    if (pick < 86) return enc_j(20'($urandom), rd);
    return $urandom();
  endfunction

  task automatic idle_source(int unsigned n);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= $urandom();
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one word and hold it until taken
  task automatic send_instr(logic [31:0] w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 5) == 0) idle_source($urandom_range(1, 12));
  endtask

  // Result sink with bursts of back-pressure
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      sink_hold     <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Note the instruction before the result so a same-edge pair stays in order
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) mirror.note_instr(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) mirror.check_commit(m_axis_tdata);
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    mirror = new();
    directed = {
      enc_i(rvc_pkg::OPC_ITYPE, 12'h800, 5'd0, rvc_pkg::F3_ADD, 5'd1),  // most negative imm
      enc_i(rvc_pkg::OPC_ITYPE, 12'h7ff, 5'd0, rvc_pkg::F3_ADD, 5'd2),  // most positive imm
      enc_r(rvc_pkg::F7_BASE, 5'd2, 5'd1, rvc_pkg::F3_ADD, 5'd3),
      enc_r(rvc_pkg::F7_ALT, 5'd2, 5'd1, rvc_pkg::F3_ADD, 5'd4),
      enc_r(rvc_pkg::F7_BASE, 5'd2, 5'd3, rvc_pkg::F3_AND, 5'd5),
      enc_r(rvc_pkg::F7_BASE, 5'd2, 5'd1, rvc_pkg::F3_OR, 5'd6),
      enc_r(rvc_pkg::F7_MULDIV, 5'd3, 5'd3, rvc_pkg::F3_ADD, 5'd7),
      enc_r(rvc_pkg::F7_MULDIV, 5'd1, 5'd1, rvc_pkg::F3_ADD, 5'd15),
      enc_r(rvc_pkg::F7_ALT, 5'd2, 5'd3, rvc_pkg::F3_AND, 5'd8),        // no such R operation
      enc_i(rvc_pkg::OPC_ITYPE, 12'hfff, 5'd2, rvc_pkg::F3_AND, 5'd9),  // funct7 bits all set
      enc_i(rvc_pkg::OPC_ITYPE, 12'h800, 5'd2, rvc_pkg::F3_OR, 5'd16),
      enc_i(rvc_pkg::OPC_ITYPE, 12'h123, 5'd3, 3'($urandom_range(1, 5)), 5'd10),
      enc_i(rvc_pkg::OPC_ITYPE, 12'h005, 5'd2, rvc_pkg::F3_ADD, 5'd0),  // write to x0
      enc_r(rvc_pkg::F7_BASE, 5'd2, 5'd1, rvc_pkg::F3_ADD, 5'd0),
      enc_s(12'h004, 5'd3, 5'd0, 3'($urandom)),
      enc_i(rvc_pkg::OPC_LOAD, 12'h004, 5'd0, 3'($urandom), 5'd11),
      enc_s(12'hffc, 5'd2, 5'd0, 3'($urandom)),                         // address wraps
      enc_i(rvc_pkg::OPC_LOAD, 12'h3fc, 5'd0, 3'($urandom), 5'd12),
      enc_i(rvc_pkg::OPC_LOAD, 12'h7ff, 5'd1, 3'($urandom), 5'd13),
      enc_s(12'h7ff, 5'd0, 5'd1, 3'($urandom)),
      enc_b(12'h004, 5'd1, 5'd1, 3'($urandom)),                         // taken
      enc_b(12'h004, 5'd2, 5'd1, 3'($urandom)),                         // not taken
      enc_j(20'h80000, 5'd14),
      enc_j(20'h7ffff, 5'd14),
      32'hffff_ffff,
      32'h0000_0000
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      maybe_gap();
      send_instr(directed[i]);
    end

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // Alternate stretches with and without gaps; none in the tail
      if (i % 100 == 0)
        gaps_on <= (i + QUIET_TAIL < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
      if (i + QUIET_TAIL == RANDOM_ITEMS) gaps_on <= 1'b0;
      maybe_gap();
      send_instr(rand_instr());
    end
    s_axis_tvalid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mirror.mismatches == 0 && mirror.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rvc_pkg.sv
rtl/core/rvc_regfile.sv
rtl/core/rvc_exec.sv
rtl/core/single_cycle_rv32_subset_core.sv
tb/single_cycle_rv32_subset_core_tb.sv
